// ===== rtl/url_percent_decoder_assert.svh =====
// Assertion macros shared by the decoder checker.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Condition in one cycle implies consequence in the next; off during reset.
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("url_percent_decoder: next-cycle check failed");

// Condition implies consequence in the same cycle; off during reset.
`define UPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("url_percent_decoder: same-cycle check failed");

// Checks the cycle that follows a reset edge.
`define UPD_ASSERT_RESET(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
    else $error("url_percent_decoder: post-reset check failed");

`endif

// ===== rtl/upd_pkg.sv =====
// Shared types, constants and decode helpers for the percent decoder.
package upd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int UPD_MAX_RES = 3;
  localparam int UPD_QDEPTH  = 4;
  localparam int UPD_QAW     = $clog2(UPD_QDEPTH);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HELD = 2'd2
  } phase_t;

  // One accepted input byte turned into 0..3 result bytes.
  typedef struct packed {
    logic [1:0]                    cnt;
    logic [UPD_MAX_RES-1:0][7:0]   bytes;
    logic                          fin;
  } upd_item_t;

  typedef struct packed {
    phase_t     ph;
    logic [7:0] held;
    logic       emit;
    logic [7:0] ch;
  } upd_simple_t;

  function automatic logic upd_is_hex(logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] upd_hex_val(logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // Byte handling from idle or after '%'.
  function automatic upd_simple_t upd_simple(phase_t ph, logic [7:0] held, logic [7:0] b);
    upd_simple_t r;
    r.ph   = PH_IDLE;
    r.held = held;
    r.emit = 1'b0;
    r.ch   = b;
    if (ph == PH_PCT) begin
      r.ph   = PH_HELD;
      r.held = b;
    end else if (b == CH_PLUS) begin
      r.emit = 1'b1;
      r.ch   = CH_SPACE;
    end else if (b == CH_PCT) begin
      r.ph = PH_PCT;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  function automatic upd_item_t upd_append(upd_item_t it, logic [7:0] b);
    upd_item_t r;
    r = it;
    if (it.cnt != 2'(UPD_MAX_RES)) begin
      r.bytes[it.cnt] = b;
      r.cnt           = it.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/upd_front.sv =====
// Front end: takes input bytes, tracks escape phase, builds result items.
module upd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        in_data_byte,
  input  logic              in_is_final,
  input  logic              q_full,
  output logic              q_push,
  output upd_pkg::upd_item_t q_wdata
);
  import upd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  upd_item_t   it;
  upd_simple_t s1, s2;
  logic        accept;

  assign accept = push && !q_full;

  always_comb begin
    it        = '0;
    it.fin    = in_is_final;
    s1        = '0;
    s2        = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (phase_r == PH_HELD) begin
      if (!upd_is_hex(held_r)) begin
        it = upd_append(it, CH_PCT);
        s1 = upd_simple(PH_IDLE, held_r, held_r);
        if (s1.emit) begin
          it = upd_append(it, s1.ch);
        end
        s2 = upd_simple(s1.ph, s1.held, in_data_byte);
        if (s2.emit) begin
          it = upd_append(it, s2.ch);
        end
        phase_nxt = s2.ph;
        held_nxt  = s2.held;
      end else if (!upd_is_hex(in_data_byte)) begin
        it = upd_append(it, CH_PCT);
        it = upd_append(it, held_r);
        s2 = upd_simple(PH_IDLE, held_r, in_data_byte);
        if (s2.emit) begin
          it = upd_append(it, s2.ch);
        end
        phase_nxt = s2.ph;
        held_nxt  = s2.held;
      end else begin
        it = upd_append(it, {upd_hex_val(held_r), upd_hex_val(in_data_byte)});
        phase_nxt = PH_IDLE;
      end
    end else begin
      s2 = upd_simple((phase_r == PH_PCT) ? PH_PCT : PH_IDLE, held_r, in_data_byte);
      if (s2.emit) begin
        it = upd_append(it, s2.ch);
      end
      phase_nxt = s2.ph;
      held_nxt  = s2.held;
    end
    if (in_is_final) begin
      if (phase_nxt == PH_PCT) begin
        it = upd_append(it, CH_PCT);
      end else if (phase_nxt == PH_HELD) begin
        it = upd_append(it, CH_PCT);
        it = upd_append(it, held_nxt);
      end
      phase_nxt = PH_IDLE;
      held_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  assign q_push  = accept && (it.cnt != 2'd0);
  assign q_wdata = it;

endmodule

// ===== rtl/upd_fifo.sv =====
// Short item queue between front end and output serializer.
module upd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_push,
  input  upd_pkg::upd_item_t q_wdata,
  input  logic               q_pop,
  output upd_pkg::upd_item_t q_rdata,
  output logic               q_full,
  output logic               q_empty
);
  import upd_pkg::*;

  upd_item_t          mem_r [UPD_QDEPTH];
  logic [UPD_QAW-1:0] wptr_r, wptr_nxt;
  logic [UPD_QAW-1:0] rptr_r, rptr_nxt;
  logic [UPD_QAW:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == (UPD_QAW+1)'(UPD_QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (q_push) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (q_pop) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (q_pop && !q_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/upd_back.sv =====
// Back end: holds one item and presents its result bytes one per cycle while pop is high.
module upd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  upd_pkg::upd_item_t q_rdata,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               out_run_last,
  output logic               out_string_end
);
  import upd_pkg::*;

  upd_item_t  cur_r;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       last, take, load;

  assign last  = (idx_r == (cur_r.cnt - 2'd1));
  assign take  = busy_r && pop;
  assign load  = !busy_r || (take && last);
  assign q_pop = load && !q_empty;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = !q_empty;
      idx_nxt  = '0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
  end

  always_comb begin
    case (idx_r)
      2'd0:    out_byte = cur_r.bytes[0];
      2'd1:    out_byte = cur_r.bytes[1];
      default: out_byte = cur_r.bytes[2];
    endcase
  end

  assign empty          = !busy_r;
  assign out_run_last   = last;
  assign out_string_end = last && cur_r.fin;

endmodule

// ===== rtl/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
//
//   channel   handshake          payload
//   input     push / full        in_data_byte[7:0], in_is_final
//   result    pop / empty        out_byte[7:0], out_run_last, out_string_end
//
// One input byte is taken every cycle while the item queue (4 entries) has room.
// Results leave one per cycle while pop is high; an input byte yields 0 to 3 of them.
// A byte's first result passes through the item queue, then the back-end item register.
// Reset clears the escape phase, held byte, queue pointers and output stage.
// Either side may stall at any time; the queue absorbs the difference.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_final,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);
  import upd_pkg::*;

  upd_item_t q_wdata, q_rdata;
  logic      q_push, q_pop, q_full, q_empty;

  assign full = q_full;

  upd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_data_byte (in_data_byte),
    .in_is_final  (in_is_final),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  upd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  upd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule

// ===== rtl/upd_checker.sv =====
// Port-level checker for the percent decoder, bound to the top level.
`include "url_percent_decoder_assert.svh"

module upd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_string_end
);

  `UPD_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_byte))
  `UPD_ASSERT_NOW(a_end_is_last, clk, rst_n, !empty && out_string_end, out_run_last)
  `UPD_ASSERT_RESET(a_rst_empty, clk, rst_n, empty && !full)
  `UPD_ASSERT_NEXT(a_one_ahead, clk, rst_n, empty && !full, !full)

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);

// ===== tb/url_percent_decoder_checker.sv =====
// Checker for the percent decoder: predicts decoded bytes and compares each popped result.
module url_percent_decoder_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_final,
  input  logic       pop,
  input  logic       empty,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  input  logic       out_string_end,
  output int         fail_count,
  output int         pending,
  output int         n_in,
  output int         n_out,
  output int         n_strings,
  output int         n_escapes,
  output int         n_malformed
);
  timeunit 1ns;
  timeprecision 1ps;
  import upd_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       byte_last;
    logic       str_end;
  } decoded_t;

  phase_t     esc_phase;
  logic [7:0] esc_held;
  logic [7:0] burst[$];
  decoded_t   decoded_q[$];

  function automatic logic hex_ok(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else begin
      v = (c | 8'h20) - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  task automatic put_byte(input logic [7:0] b);
    if (burst.size() < UPD_MAX_RES) begin
      burst.push_back(b);
    end
  endtask

  // byte seen from idle or right after '%'
  task automatic decode_plain(input logic [7:0] b);
    if (esc_phase == PH_PCT) begin
      esc_held = b;
      esc_phase = PH_HELD;
    end else begin
      esc_phase = PH_IDLE;
      if (b == CH_PLUS) begin
        put_byte(CH_SPACE);
      end else if (b == CH_PCT) begin
        esc_phase = PH_PCT;
      end else begin
        put_byte(b);
      end
    end
  endtask

  task automatic decode_input(input logic [7:0] b, input logic fin);
    logic [7:0] h;
    decoded_t   d;
    int         k;
    burst.delete();
    if (esc_phase == PH_HELD) begin
      h = esc_held;
      esc_phase = PH_IDLE;
      if (!hex_ok(h)) begin
        put_byte(CH_PCT);
        decode_plain(h);
        decode_plain(b);
        n_malformed++;
      end else if (!hex_ok(b)) begin
        put_byte(CH_PCT);
        put_byte(h);
        decode_plain(b);
        n_malformed++;
      end else begin
        put_byte({nibble_of(h), nibble_of(b)});
        n_escapes++;
      end
    end else begin
      decode_plain(b);
    end
    if (fin) begin
      if (esc_phase == PH_PCT) begin
        put_byte(CH_PCT);
      end else if (esc_phase == PH_HELD) begin
        put_byte(CH_PCT);
        put_byte(esc_held);
      end
      esc_phase = PH_IDLE;
      esc_held = '0;
      n_strings++;
    end
    for (k = 0; k < burst.size(); k++) begin
      d.value     = burst[k];
      d.byte_last = (k == burst.size() - 1);
      d.str_end   = d.byte_last && fin;
      decoded_q.push_back(d);
    end
  endtask

  always @(posedge clk) begin
    decoded_t d;
    if (!rst_n) begin
      esc_phase   = PH_IDLE;
      esc_held    = '0;
      decoded_q.delete();
      fail_count  = 0;
      n_in        = 0;
      n_out       = 0;
      n_strings   = 0;
      n_escapes   = 0;
      n_malformed = 0;
    end else begin
      if (push && !full) begin
        decode_input(in_data_byte, in_is_final);
        n_in++;
      end
      if (pop && !empty) begin
        n_out++;
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %h", out_byte);
          fail_count++;
        end else begin
          d = decoded_q.pop_front();
          if (out_byte !== d.value) begin
            $error("out_byte: expected %h, got %h", d.value, out_byte);
            fail_count++;
          end
          if (out_run_last !== d.byte_last) begin
            $error("out_run_last: expected %b, got %b", d.byte_last, out_run_last);
            fail_count++;
          end
          if (out_string_end !== d.str_end) begin
            $error("out_string_end: expected %b, got %b", d.str_end, out_string_end);
            fail_count++;
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the percent decoder testbench: clock, reset, stimulus, stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import upd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 60;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_data_byte = '0;
  logic       in_is_final = 1'b0;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_end;

  int fail_count, pending, n_in, n_out, n_strings, n_escapes, n_malformed;
  int n_sent = 0;
  int stuck_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit tx_gaps_now = 1'b0;
  bit long_hold_req = 1'b0;

  url_percent_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data_byte   (in_data_byte),
    .in_is_final    (in_is_final),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  url_percent_decoder_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data_byte   (in_data_byte),
    .in_is_final    (in_is_final),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .fail_count     (fail_count),
    .pending        (pending),
    .n_in           (n_in),
    .n_out          (n_out),
    .n_strings      (n_strings),
    .n_escapes      (n_escapes),
    .n_malformed    (n_malformed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles, %0d results pending",
                 stuck_cycles, pending);
        $display("** url_percent_decoder: FAILED **");
        $finish;
      end
    end
  end

  // result side: short random stalls, quiet stretches, one long hold on request
  initial begin
    int hold;
    int calm;
    hold = 0;
    calm = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
        calm = 0;
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (!rx_idle || calm > 0) begin
        pop <= 1'b1;
        if (calm > 0) calm--;
      end else if ($urandom_range(0, 29) == 0) begin
        pop <= 1'b1;
        calm = 30;
      end else if ($urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (tx_gaps_now && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= b;
    in_is_final  <= fin;
    do @(posedge clk); while (full);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) begin
      send_byte(s.getc(k), k == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  task automatic send_random_string();
    logic [7:0] s[$];
    int len;
    int k;
    int kind;
    len = $urandom_range(1, 8);
    for (k = 0; k < len; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        s.push_back(CH_PCT);
        s.push_back(hex_char());
        s.push_back(hex_char());
      end else if (kind < 53) begin
        s.push_back(CH_PLUS);
      end else if (kind < 60) begin
        s.push_back(CH_PCT);
      end else if (kind < 67) begin
        s.push_back(CH_PCT);
        s.push_back(8'($urandom_range(0, 255)));
        s.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 72) begin
        s.push_back(CH_PCT);
        s.push_back(hex_char());
        s.push_back(8'($urandom_range(0, 255)));
      end else begin
        s.push_back(8'($urandom_range(0, 255)));
      end
    end
    tx_gaps_now = tx_idle && ($urandom_range(0, 2) != 0);
    for (k = 0; k < s.size(); k++) begin
      send_byte(s[k], k == s.size() - 1);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: byte extremes, '+', hex case, escape of zero, broken escapes,
    // held '%' and '+', and strings ending inside an escape
    tx_gaps_now = 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("a+");
    send_text("%aF%00");
    send_text("%zq%4z");
    send_text("%%+x");
    send_text("%");
    send_text("%4");
    send_text("%g");

    while (n_sent < 200) send_random_string();
    long_hold_req = 1'b1;
    while (n_sent < 270) send_random_string();
    wait_drained();
    while (n_sent < 430) send_random_string();

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (n_sent < 525) send_random_string();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d input bytes in %0d strings, %0d results checked",
             n_in, n_strings, n_out);
    $display("escapes: %0d decoded, %0d malformed", n_escapes, n_malformed);
    if (fail_count == 0 && pending == 0) begin
      $display("** url_percent_decoder: PASSED **");
    end else begin
      $display("** url_percent_decoder: FAILED **");
    end
    $finish;
  end

endmodule
